@@ rtl/clipped_line_rasterizer_defines.svh @@
`ifndef CLIPPED_LINE_RASTERIZER_DEFINES_SVH
`define CLIPPED_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle check: when ante holds, cons holds at this edge.
`define CLR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle check: when ante holds, cons holds at the following edge.
`define CLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/clr_pkg.sv @@
`timescale 1ns / 1ps

package clr_pkg;

   localparam int PIX_BITS   = 12;
   localparam int COLOR_BITS = 32;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [PIX_BITS-1:0] SCREEN_WIDTH_RESET  = 12'd640;
   localparam logic [PIX_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd480;

   typedef struct packed {
      logic [PIX_BITS-1:0]   pixel_x;
      logic [PIX_BITS-1:0]   pixel_y;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  pixel_valid;
      logic                  line_done;
   } pixel_word_type;

endpackage

@@ rtl/clr_walk.sv @@
`timescale 1ns / 1ps

module clr_walk
   import clr_pkg::*;
#(
   parameter int COORD_BITS = 13
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load_en,
   input  logic                         step_en,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   input  logic [COLOR_BITS-1:0]        line_color,
   input  logic [PIX_BITS-1:0]          screen_width,
   input  logic [PIX_BITS-1:0]          screen_height,
   output pixel_word_type               word
);

   localparam int XW = COORD_BITS + 2;
   localparam int DW = COORD_BITS + 1;
   localparam int LW = 2 * COORD_BITS + 2;
   localparam int CW = XW + PIX_BITS;

   logic signed [XW-1:0]         walk_x_ff, walk_x_in;
   logic signed [XW-1:0]         walk_y_ff, walk_y_in;
   logic signed [COORD_BITS-1:0] goal_x_ff, goal_y_ff;
   logic signed [DW-1:0]         delta_x_ff, delta_y_ff;
   logic signed [LW-1:0]         offset_ff, offset_in;
   logic                         down_ff, shallow_ff, active_ff;
   logic [COLOR_BITS-1:0]        color_ff;

   // load path: order endpoints so x rises
   logic                         swap;
   logic signed [COORD_BITS-1:0] ax, ay, bx, by;
   logic signed [DW-1:0]         dx_load, dy_load, ady_load;

   assign swap     = end_x < start_x;
   assign ax       = swap ? end_x   : start_x;
   assign ay       = swap ? end_y   : start_y;
   assign bx       = swap ? start_x : end_x;
   assign by       = swap ? start_y : end_y;
   assign dx_load  = DW'(bx) - DW'(ax);
   assign dy_load  = DW'(by) - DW'(ay);
   assign ady_load = dy_load[DW-1] ? -dy_load : dy_load;

   // step path
   logic                 still, finished, onscreen;
   logic [CW-1:0]        wx_wide, wy_wide;
   logic                 l_pos, l_neg, minor, x_inc, y_step;
   logic signed [LW-1:0] add_x, add_y;

   assign still = (walk_x_ff < XW'(goal_x_ff)) ||
                  (down_ff ? (walk_y_ff < XW'(goal_y_ff)) : (walk_y_ff > XW'(goal_y_ff)));
   assign finished = !active_ff || !still;

   assign wx_wide  = CW'($unsigned(walk_x_ff));
   assign wy_wide  = CW'($unsigned(walk_y_ff));
   assign onscreen = !walk_x_ff[XW-1] && !walk_y_ff[XW-1] &&
                     (wx_wide < CW'(screen_width)) && (wy_wide < CW'(screen_height));

   // minor step when offset times direction times slope sign is positive
   assign l_neg  = offset_ff[LW-1];
   assign l_pos  = !offset_ff[LW-1] && (offset_ff != '0);
   assign minor  = (down_ff ^ shallow_ff) ? l_neg : l_pos;
   assign x_inc  = shallow_ff | minor;
   assign y_step = !shallow_ff | minor;

   assign add_x     = x_inc ? LW'(delta_y_ff) : '0;
   assign add_y     = !y_step ? '0 : (down_ff ? -LW'(delta_x_ff) : LW'(delta_x_ff));
   assign offset_in = offset_ff + add_x + add_y;
   assign walk_x_in = walk_x_ff + {{(XW-1){1'b0}}, x_inc};
   assign walk_y_in = !y_step ? walk_y_ff :
                      (down_ff ? walk_y_ff + XW'(1) : walk_y_ff - XW'(1));

   always_comb begin
      word = '0;
      if (finished) begin
         word.line_done = 1'b1;
      end else begin
         word.pixel_color = color_ff;
         word.pixel_valid = onscreen;
         if (onscreen) begin
            word.pixel_x = PIX_BITS'(wx_wide);
            word.pixel_y = PIX_BITS'(wy_wide);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (load_en) begin
         active_ff <= 1'b1;
      end else if (step_en && finished) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         walk_x_ff  <= XW'(ax);
         walk_y_ff  <= XW'(ay);
         goal_x_ff  <= bx;
         goal_y_ff  <= by;
         delta_x_ff <= dx_load;
         delta_y_ff <= dy_load;
         offset_ff  <= '0;
         down_ff    <= !dy_load[DW-1] && (dy_load != '0);
         shallow_ff <= (dx_load != '0) && (ady_load <= dx_load);
         color_ff   <= line_color;
      end else if (step_en && !finished) begin
         walk_x_ff <= walk_x_in;
         walk_y_ff <= walk_y_in;
         offset_ff <= offset_in;
      end
   end

endmodule

@@ rtl/clr_out_reg.sv @@
`timescale 1ns / 1ps

module clr_out_reg
   import clr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  pixel_word_type word_in,
   input  logic           stall,
   output logic           valid,
   output pixel_word_type word_out
);

   logic           valid_ff, valid_in;
   pixel_word_type word_ff;

   // hold while the taker stalls, refill on every accepted step
   assign valid_in = load | (valid_ff & stall);
   assign valid    = valid_ff;
   assign word_out = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

endmodule

@@ rtl/clipped_line_rasterizer.sv @@
`timescale 1ns / 1ps
// channel   ports                         word
// request   req_valid / req_stall         req_func, start/end endpoints, req_line_color
// response  rsp_valid / rsp_stall         rsp_pixel_x/_y, _color, _valid, rsp_line_done
// csr       csr_write (no handshake)      csr_index, csr_data
//
// One word a cycle: a request is taken every cycle unless a step is held by a stalled response,
// and a step's pixel appears in the next cycle. The walk registers and the response register
// are the only stages; each step is a sign test and one three-term add.
// Reset clears the walk (no line loaded) and the response valid flag, and sets 640 x 480.
// A load is taken even while a response waits; a step waits only while the response is stalled.

`include "clipped_line_rasterizer_defines.svh"

module clipped_line_rasterizer
   import clr_pkg::*;
#(
   parameter int COORD_BITS = 13
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic [COLOR_BITS-1:0]        req_line_color,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [PIX_BITS-1:0]          rsp_pixel_x,
   output logic [PIX_BITS-1:0]          rsp_pixel_y,
   output logic [COLOR_BITS-1:0]        rsp_pixel_color,
   output logic                         rsp_pixel_valid,
   output logic                         rsp_line_done,

   input  logic                         csr_write,
   input  logic                         csr_index,
   input  logic [PIX_BITS-1:0]          csr_data
);

   logic [PIX_BITS-1:0] width_ff, height_ff;
   logic                req_accept, load_en, step_en;
   pixel_word_type      walk_word, rsp_word;

   // screen size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RESET;
         height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_data;
            CSR_SCREEN_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // a step needs a free response slot; a load produces no word and never waits
   assign req_stall  = rsp_valid & rsp_stall & (req_func == FUNC_STEP);
   assign req_accept = req_valid & !req_stall;
   assign load_en    = req_accept & (req_func == FUNC_LOAD);
   assign step_en    = req_accept & (req_func == FUNC_STEP);

   clr_walk #(
      .COORD_BITS (COORD_BITS)
   ) u_walk (
      .clock         (clock),
      .reset         (reset),
      .load_en       (load_en),
      .step_en       (step_en),
      .start_x       (req_start_x),
      .start_y       (req_start_y),
      .end_x         (req_end_x),
      .end_y         (req_end_y),
      .line_color    (req_line_color),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .word          (walk_word)
   );

   clr_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (step_en),
      .word_in  (walk_word),
      .stall    (rsp_stall),
      .valid    (rsp_valid),
      .word_out (rsp_word)
   );

   assign rsp_pixel_x     = rsp_word.pixel_x;
   assign rsp_pixel_y     = rsp_word.pixel_y;
   assign rsp_pixel_color = rsp_word.pixel_color;
   assign rsp_pixel_valid = rsp_word.pixel_valid;
   assign rsp_line_done   = rsp_word.line_done;

   // every accepted step yields a response word on the next edge
   `CLR_ASSERT_NEXT(a_step_gives_word, clock, reset, step_en, rsp_valid, "step lost its word")
   // an ended walk never reports a drawable pixel
   `CLR_ASSERT_NOW(a_done_not_drawn, clock, reset, rsp_valid && rsp_line_done, !rsp_pixel_valid && rsp_pixel_color == '0, "done word carries a pixel")
   // clipped or empty words carry zero coordinates
   `CLR_ASSERT_NOW(a_clipped_zero, clock, reset, rsp_valid && !rsp_pixel_valid, rsp_pixel_x == '0 && rsp_pixel_y == '0, "clipped word has coordinates")

endmodule
